[rtl/macd_pkg.sv]
package macd_pkg;

    localparam int PERIOD_MAX_DEFAULT = 256;

    localparam int PRICE_W   = 32;
    localparam int OUT_W     = 36;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Q1.24 coefficients and the table divider.
    localparam int FRAC  = 24;
    localparam int K_W   = 25;
    localparam int DIV_W = 26;
    localparam int CHUNK = 24;

    localparam logic [CFG_W-1:0] FAST_RESET   = 9'd12;
    localparam logic [CFG_W-1:0] SLOW_RESET   = 9'd26;
    localparam logic [CFG_W-1:0] SIGNAL_RESET = 9'd9;

    localparam logic signed [63:0] OUT_MAX = 64'sd34359738367;
    localparam logic signed [63:0] OUT_MIN = -64'sd34359738368;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAST   = 2'd0,
        REG_SLOW   = 2'd1,
        REG_SIGNAL = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        U_FAST   = 2'd0,
        U_SLOW   = 2'd1,
        U_SIGNAL = 2'd2
    } unit_t;

    // What one average does with the current sample.
    typedef enum logic [1:0] {
        K_SKIP = 2'd0,
        K_ADD  = 2'd1,
        K_SEED = 2'd2,
        K_EMA  = 2'd3
    } kind_t;

    typedef struct packed {
        logic  tbl_start;
        logic  load;
        logic  add;
        logic  mul_start;
        logic  mul_step;
        logic  apply;
        logic  macd;
        logic  fin;
        unit_t unit;
    } cmd_t;

    typedef struct packed {
        logic  tbl_busy;
        kind_t kind;
        logic  mul_last;
        logic  out_free;
    } status_t;

    function automatic logic signed [OUT_W-1:0] sat36(input logic signed [63:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else if (v < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/macd_ctrl.sv]
module macd_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             cfg_valid,
    input  logic [macd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  macd_pkg::status_t                status,
    output logic                             s_ready,
    output macd_pkg::cmd_t                   cmd
);

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_TBL   = 8'b0000_0010,
        ST_IDLE  = 8'b0000_0100,
        ST_EVAL  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_APPLY = 8'b0010_0000,
        ST_MACD  = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    macd_pkg::unit_t     unit_reg, unit_next;
    logic                cfg_hit;

    always_comb begin
        unique case (cfg_index)
            macd_pkg::REG_FAST, macd_pkg::REG_SLOW, macd_pkg::REG_SIGNAL: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE) && !cfg_valid;

    always_comb begin
        state_next = state_reg;
        unit_next  = unit_reg;
        cmd        = '0;
        cmd.unit   = unit_reg;
        unique case (state_reg)
            ST_INIT: begin
                cmd.tbl_start = 1'b1;
                state_next    = ST_TBL;
            end
            ST_TBL: begin
                if (!status.tbl_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && !cfg_valid) begin
                    cmd.load   = 1'b1;
                    unit_next  = macd_pkg::U_FAST;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL, ST_APPLY: begin
                if (state_reg == ST_EVAL &&
                    (status.kind == macd_pkg::K_SEED || status.kind == macd_pkg::K_EMA)) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.add   = (state_reg == ST_EVAL) && (status.kind == macd_pkg::K_ADD);
                    cmd.apply = (state_reg == ST_APPLY);
                    unique case (unit_reg)
                        macd_pkg::U_FAST: begin
                            unit_next  = macd_pkg::U_SLOW;
                            state_next = ST_EVAL;
                        end
                        macd_pkg::U_SLOW:   state_next = ST_MACD;
                        macd_pkg::U_SIGNAL: state_next = ST_FIN;
                        default:            state_next = ST_INIT;
                    endcase
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.mul_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_MACD: begin
                cmd.macd   = 1'b1;
                unit_next  = macd_pkg::U_SIGNAL;
                state_next = ST_EVAL;
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
        // A period write restarts the coefficient tables.
        if (cfg_hit) begin
            state_next = ST_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            unit_reg  <= macd_pkg::U_FAST;
        end else begin
            state_reg <= state_next;
            unit_reg  <= unit_next;
        end
    end

endmodule

[rtl/macd_dpath.sv]
module macd_dpath #(
    parameter int PERIOD_MAX = macd_pkg::PERIOD_MAX_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  macd_pkg::cmd_t                       cmd,
    output macd_pkg::status_t                    status,
    input  logic                                 cfg_valid,
    input  logic [macd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [macd_pkg::CFG_W-1:0]           cfg_data,
    input  logic [macd_pkg::PRICE_W-1:0]         s_price,
    input  logic                                 s_new_series,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic                                 m_macd_valid,
    output logic signed [macd_pkg::OUT_W-1:0]    m_macd_value,
    output logic                                 m_signal_valid,
    output logic signed [macd_pkg::OUT_W-1:0]    m_signal_value,
    output logic signed [macd_pkg::OUT_W-1:0]    m_histogram_value
);

    localparam int LP    = $clog2(PERIOD_MAX);
    localparam int PW    = $clog2(PERIOD_MAX + 1);
    localparam int DVW   = $clog2(PERIOD_MAX + 2);
    localparam int CNTW  = $clog2(2 * PERIOD_MAX + 1);
    localparam int MCW   = $clog2(PERIOD_MAX + 2);
    localparam int AW    = 38 + LP;
    localparam int NCH   = (AW + macd_pkg::CHUNK - 1) / macd_pkg::CHUNK;
    localparam int MW    = NCH * macd_pkg::CHUNK;
    localparam int PRW   = MW + macd_pkg::K_W;
    localparam int PPW   = macd_pkg::CHUNK + macd_pkg::K_W;
    localparam int CHW   = $clog2(NCH + 1);
    localparam int DBW   = $clog2(macd_pkg::DIV_W);

    function automatic logic [PW-1:0] eff(input logic [macd_pkg::CFG_W-1:0] r);
        logic [PW-1:0] p;
        if (r == '0) begin
            p = PW'(1);
        end else if (32'(r) > PERIOD_MAX) begin
            p = PW'(PERIOD_MAX);
        end else begin
            p = PW'(r);
        end
        return p;
    endfunction

    // Period registers and effective periods.
    logic [macd_pkg::CFG_W-1:0] period_reg [3];
    logic [PW-1:0]              per_eff [3];
    logic                       cfg_hit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            per_eff[i] = eff(period_reg[i]);
        end
        unique case (cfg_index)
            macd_pkg::REG_FAST, macd_pkg::REG_SLOW, macd_pkg::REG_SIGNAL: cfg_hit = cfg_valid;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg[0] <= macd_pkg::FAST_RESET;
            period_reg[1] <= macd_pkg::SLOW_RESET;
            period_reg[2] <= macd_pkg::SIGNAL_RESET;
        end else if (cfg_hit) begin
            period_reg[cfg_index] <= cfg_data;
        end
    end

    // Restoring divider for the gain and seed reciprocal tables.
    logic [macd_pkg::K_W-1:0]   gain_reg [3];
    logic [macd_pkg::K_W-1:0]   recip_reg [3];
    logic                       tbl_busy_reg;
    logic [2:0]                 div_ent_reg;
    logic [DBW-1:0]             div_bit_reg;
    logic [DVW-1:0]             div_d_reg;
    logic [DVW-1:0]             div_rem_reg;
    logic [macd_pkg::DIV_W-1:0] div_quo_reg;

    logic [2:0]                 setup_ent;
    logic [1:0]                 setup_idx;
    logic [PW-1:0]              setup_p;
    logic [DVW-1:0]             setup_d;
    logic [macd_pkg::DIV_W-1:0] setup_n;
    logic [DVW:0]               div_trial;
    logic                       div_ge;
    logic [DVW-1:0]             div_rem_next;
    logic [macd_pkg::DIV_W-1:0] div_quo_next;
    logic [1:0]                 store_idx;
    logic                       div_last;

    always_comb begin
        setup_ent = cmd.tbl_start ? 3'd0 : 3'(div_ent_reg + 3'd1);
        setup_idx = (setup_ent < 3'd3) ? setup_ent[1:0] : 2'(setup_ent - 3'd3);
        setup_p   = per_eff[setup_idx];
        if (setup_ent < 3'd3) begin
            setup_d = DVW'(setup_p) + DVW'(1);
            setup_n = (macd_pkg::DIV_W'(1) << 25) + macd_pkg::DIV_W'(setup_d >> 1);
        end else begin
            setup_d = DVW'(setup_p);
            setup_n = (macd_pkg::DIV_W'(1) << 24) + macd_pkg::DIV_W'(setup_p >> 1);
        end
        div_trial    = {div_rem_reg, div_quo_reg[macd_pkg::DIV_W-1]};
        div_ge       = div_trial >= {1'b0, div_d_reg};
        div_rem_next = div_ge ? DVW'(div_trial - {1'b0, div_d_reg}) : DVW'(div_trial);
        div_quo_next = {div_quo_reg[macd_pkg::DIV_W-2:0], div_ge};
        store_idx    = (div_ent_reg < 3'd3) ? div_ent_reg[1:0] : 2'(div_ent_reg - 3'd3);
        div_last     = (div_bit_reg == DBW'(macd_pkg::DIV_W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_busy_reg <= 1'b0;
            div_ent_reg  <= '0;
            div_bit_reg  <= '0;
        end else if (cmd.tbl_start) begin
            tbl_busy_reg <= 1'b1;
            div_ent_reg  <= '0;
            div_bit_reg  <= '0;
        end else if (tbl_busy_reg) begin
            if (div_last) begin
                div_bit_reg <= '0;
                div_ent_reg <= 3'(div_ent_reg + 3'd1);
                if (div_ent_reg == 3'd5) begin
                    tbl_busy_reg <= 1'b0;
                end
            end else begin
                div_bit_reg <= DBW'(div_bit_reg + DBW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tbl_start || (tbl_busy_reg && div_last)) begin
            div_d_reg   <= setup_d;
            div_rem_reg <= '0;
            div_quo_reg <= setup_n;
        end else if (tbl_busy_reg) begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
        end
        if (tbl_busy_reg && div_last && !cmd.tbl_start) begin
            if (div_ent_reg < 3'd3) begin
                gain_reg[store_idx] <= div_quo_next[macd_pkg::K_W-1:0];
            end else begin
                recip_reg[store_idx] <= div_quo_next[macd_pkg::K_W-1:0];
            end
        end
    end

    // Series state.
    logic [macd_pkg::PRICE_W-1:0]     price_reg;
    logic [CNTW-1:0]                  price_count_reg;
    logic [MCW-1:0]                   macd_count_reg;
    logic signed [AW-1:0]             avg_reg [3];
    logic                             mvalid_reg;
    logic signed [macd_pkg::OUT_W-1:0] macd_reg;

    // Shared sign-magnitude multiplier, one chunk per cycle.
    logic [MW-1:0]            mag_reg;
    logic                     neg_reg;
    logic [macd_pkg::K_W-1:0] k_reg;
    logic [PPW-1:0]           pp_reg;
    logic [PRW-1:0]           acc_reg;
    logic [CHW-1:0]           step_reg;

    logic [CNTW-1:0]          n_cur;
    logic [CNTW-1:0]          p_cur;
    macd_pkg::kind_t          kind;
    logic signed [AW-1:0]     x_cur;
    logic signed [AW-1:0]     avg_cur;
    logic signed [AW-1:0]     opnd;
    logic [AW-1:0]            opnd_mag;
    logic [PRW-1:0]           rnd_full;
    logic [AW-1:0]            r_mag;
    logic signed [AW-1:0]     r_s;
    logic [CNTW-1:0]          pc_base;
    logic [CNTW-1:0]          pc_next;
    logic                     mv;
    logic                     sv;
    logic signed [macd_pkg::OUT_W-1:0] sig_v;

    always_comb begin
        n_cur = (cmd.unit == macd_pkg::U_SIGNAL) ? CNTW'(macd_count_reg) : price_count_reg;
        p_cur = CNTW'(per_eff[cmd.unit]);
        if (cmd.unit == macd_pkg::U_SIGNAL && !mvalid_reg) begin
            kind = macd_pkg::K_SKIP;
        end else if (n_cur < p_cur) begin
            kind = macd_pkg::K_ADD;
        end else if (n_cur == p_cur) begin
            kind = macd_pkg::K_SEED;
        end else begin
            kind = macd_pkg::K_EMA;
        end
        if (cmd.unit == macd_pkg::U_SIGNAL) begin
            x_cur = AW'(macd_reg);
        end else begin
            x_cur = $signed({{(AW - macd_pkg::PRICE_W){1'b0}}, price_reg});
        end
        avg_cur  = avg_reg[cmd.unit];
        opnd     = (kind == macd_pkg::K_SEED) ? AW'(avg_cur + x_cur) : AW'(x_cur - avg_cur);
        opnd_mag = opnd[AW-1] ? AW'(-opnd) : AW'(opnd);
        rnd_full = acc_reg + (PRW'(1) << (macd_pkg::FRAC - 1));
        r_mag    = AW'(rnd_full >> macd_pkg::FRAC);
        r_s      = neg_reg ? AW'(-$signed(r_mag)) : $signed(r_mag);
        pc_base  = s_new_series ? '0 : price_count_reg;
        pc_next  = (pc_base < CNTW'(2 * PERIOD_MAX)) ? CNTW'(pc_base + CNTW'(1)) : pc_base;
        mv       = (price_count_reg >= CNTW'(per_eff[0])) &&
                   (price_count_reg >= CNTW'(per_eff[1]));
        sv       = mvalid_reg && (CNTW'(macd_count_reg) >= CNTW'(per_eff[2]));
        sig_v    = macd_pkg::sat36(64'(avg_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            price_count_reg <= '0;
            macd_count_reg  <= '0;
            mvalid_reg      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                avg_reg[i] <= '0;
            end
        end else begin
            if (cmd.load) begin
                price_count_reg <= pc_next;
                if (s_new_series) begin
                    macd_count_reg <= '0;
                    for (int i = 0; i < 3; i++) begin
                        avg_reg[i] <= '0;
                    end
                end
            end
            if (cmd.add) begin
                avg_reg[cmd.unit] <= AW'(avg_cur + x_cur);
            end
            if (cmd.apply) begin
                if (kind == macd_pkg::K_SEED) begin
                    avg_reg[cmd.unit] <= r_s;
                end else begin
                    avg_reg[cmd.unit] <= AW'(avg_cur + r_s);
                end
            end
            if (cmd.macd) begin
                mvalid_reg <= mv;
                if (mv && (32'(macd_count_reg) < PERIOD_MAX + 1)) begin
                    macd_count_reg <= MCW'(macd_count_reg + MCW'(1));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            price_reg <= s_price;
        end
        if (cmd.macd) begin
            macd_reg <= macd_pkg::sat36(64'(avg_reg[0]) - 64'(avg_reg[1]));
        end
        if (cmd.mul_start) begin
            mag_reg  <= MW'(opnd_mag);
            neg_reg  <= opnd[AW-1];
            k_reg    <= (kind == macd_pkg::K_SEED) ? recip_reg[cmd.unit] : gain_reg[cmd.unit];
            pp_reg   <= '0;
            acc_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.mul_step) begin
            pp_reg   <= PPW'(mag_reg[MW-1 -: macd_pkg::CHUNK] * k_reg);
            mag_reg  <= mag_reg << macd_pkg::CHUNK;
            acc_reg  <= PRW'(acc_reg << macd_pkg::CHUNK) + PRW'(pp_reg);
            step_reg <= CHW'(step_reg + CHW'(1));
        end
    end

    // Output register.
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            m_macd_valid      <= mvalid_reg;
            m_macd_value      <= mvalid_reg ? macd_reg : '0;
            m_signal_valid    <= sv;
            m_signal_value    <= sv ? sig_v : '0;
            m_histogram_value <= sv ? macd_pkg::sat36(64'(macd_reg) - 64'(sig_v)) : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.tbl_busy = tbl_busy_reg;
    assign status.kind     = kind;
    assign status.mul_last = (step_reg == CHW'(NCH));
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

[rtl/macd_indicator_stream.sv]
// MACD indicator over a stream of unsigned Q16.16 prices. Each accepted price
// yields one result transfer, unless a period write cuts its work short,
// carrying MACD (fast minus slow average), its signal average and the
// histogram, all signed Q20.16 saturated to 36 bits, each with a valid flag
// once the averages are seeded by their plain means. Items are handled one at
// a time; the three average updates share one multiplier that works through
// the operand 24 bits per cycle. After reset and after every write of a period
// register the block rebuilds its gain and reciprocal tables with a bit-serial
// divider, 6 entries of 26 quotient bits, and takes no price until it is done.
// A period write also restarts the series; a write to the unused index is
// ignored. Periods of 0 act as 1 and periods above PERIOD_MAX act as
// PERIOD_MAX. A price flagged new_series restarts all averages first.
module macd_indicator_stream #(
    parameter int PERIOD_MAX = macd_pkg::PERIOD_MAX_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [macd_pkg::PRICE_W-1:0]         s_price,
    input  logic                                 s_new_series,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_macd_valid,
    output logic signed [macd_pkg::OUT_W-1:0]    m_macd_value,
    output logic                                 m_signal_valid,
    output logic signed [macd_pkg::OUT_W-1:0]    m_signal_value,
    output logic signed [macd_pkg::OUT_W-1:0]    m_histogram_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [macd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [macd_pkg::CFG_W-1:0]           cfg_data
);

    macd_pkg::cmd_t    cmd;
    macd_pkg::status_t status;

    // Register writes are always accepted.
    assign cfg_ready = 1'b1;

    // The controller sequences load, the three average updates, the MACD
    // step and the final output transfer.
    macd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .status    (status),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    // The datapath holds the averages, tables, multiplier and output register.
    macd_dpath #(
        .PERIOD_MAX (PERIOD_MAX)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_price           (s_price),
        .s_new_series      (s_new_series),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_macd_valid      (m_macd_valid),
        .m_macd_value      (m_macd_value),
        .m_signal_valid    (m_signal_valid),
        .m_signal_value    (m_signal_value),
        .m_histogram_value (m_histogram_value)
    );

endmodule

[rtl/macd_checker.sv]
module macd_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_macd_valid,
    input logic signed [macd_pkg::OUT_W-1:0]    m_macd_value,
    input logic                                 m_signal_valid,
    input logic signed [macd_pkg::OUT_W-1:0]    m_signal_value,
    input logic signed [macd_pkg::OUT_W-1:0]    m_histogram_value
);

    // A pending result is held until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // One price is worked on at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("price accepted while another is in work");

    // The signal line exists only on top of a defined MACD line.
    a_sig_needs_macd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_signal_valid |-> m_macd_valid)
        else $error("signal valid without MACD valid");

    // Undefined values are reported as zero.
    a_zero_when_undef: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_signal_valid |->
            m_signal_value == '0 && m_histogram_value == '0 &&
            (m_macd_valid || m_macd_value == '0))
        else $error("undefined result field not zero");

endmodule

bind macd_indicator_stream macd_checker u_macd_checker (.*);
